// ----- design/framebuffer_alpha_over_blend_macros.svh -----
// Assertion macros shared by the framebuffer blend design.
`ifndef FRAMEBUFFER_ALPHA_OVER_BLEND_MACROS_SVH
`define FRAMEBUFFER_ALPHA_OVER_BLEND_MACROS_SVH
`ifndef SYNTHESIS
`define FBAOB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FBAOB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FBAOB_ASSERT(label, clk, rst, prop, msg)
`define FBAOB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- design/fbaob_pkg.sv -----
// Shared types, constants and codes of the framebuffer blend design.
package fbaob_pkg;

   localparam int MAX_WIDTH_DEF  = 128;
   localparam int MAX_HEIGHT_DEF = 128;
   localparam int STORE_DEPTH_DEF = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 4 * CHAN_W;
   localparam int COORD_W    = 7;
   localparam int LIN_W      = 15;
   localparam int WT_W       = 16;
   localparam int DEN_W      = 17;
   localparam int NUM_W      = 25;
   localparam int NUM_CHAN   = 3;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STEPS  = CHAN_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W = 48;
   localparam int CSR_DATA_W = 8;

   localparam logic [1:0] OP_BLEND = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [1:0]         pad;
      pixel_type          color;
      logic [COORD_W-1:0] y_coord;
      logic [COORD_W-1:0] x_coord;
   } req_data_type;

   typedef struct packed {
      logic busy;
      logic done;
   } blend_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_BLEND,
      ST_FINISH
   } top_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_PROD,
      B_DIV,
      B_DONE
   } blend_state_type;

endpackage

// ----- design/framebuffer_alpha_over_blend.sv -----
// Top level of the RGBA framebuffer with source-over blending.
//
//   Channel  Direction  Transfer carries
//   req_     in         one operation: opcode, coordinates, source color
//   rsp_     out        the pixel as stored afterwards and the range flag
//   csr_     in         writes of frame_width and frame_height
//
// A blend passes the read, blend and finish steps from transfer in to result; a read or raw write skips the blend step.
// The blend step runs the radix-4 divider, four steps for eight quotient bits.
// The next item is taken once the previous result sits in the output register.
// Reset is synchronous; the pixel store itself is not cleared.
// A stalled result channel holds the block in its last step until the slot frees.
`include "framebuffer_alpha_over_blend_macros.svh"

module framebuffer_alpha_over_blend #(
   parameter int MAX_WIDTH  = fbaob_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fbaob_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // x_coord, y_coord, src_red, src_green, src_blue, src_alpha, zero pad
   input  logic [fbaob_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pix_red, pix_green, pix_blue, pix_alpha
   output logic [fbaob_pkg::PIXEL_W-1:0]     rsp_tdata,
   // out_of_range
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic                              csr_addr,
   input  logic [fbaob_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   fbaob_pkg::top_state_type state_ff, state_in;
   fbaob_pkg::req_data_type  req_fields;
   fbaob_pkg::pixel_type     src_ff, pix_ff, pix_in, mem_rdata, blend_pix, rsp_pix_ff;
   fbaob_pkg::blend_status_type blend_stat;

   logic [fbaob_pkg::CSR_DATA_W-1:0] frame_width_ff, frame_height_ff;
   logic [fbaob_pkg::CSR_DATA_W-1:0] eff_width, eff_height;
   logic [fbaob_pkg::LIN_W-1:0]      lin_addr;
   logic [ADDR_W-1:0]                addr_in, addr_ff;
   logic [1:0]                       op_ff;
   logic oor_in, oor_ff;
   logic req_accept, slot_free, blend_start, pix_load, mem_we, rsp_load;
   logic rsp_valid_ff, rsp_valid_in, rsp_oor_ff;

   assign req_fields = req_tdata;
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      eff_width  = (int'(frame_width_ff) < MAX_WIDTH) ? frame_width_ff
                                                       : fbaob_pkg::CSR_DATA_W'(MAX_WIDTH);
      eff_height = (int'(frame_height_ff) < MAX_HEIGHT) ? frame_height_ff
                                                         : fbaob_pkg::CSR_DATA_W'(MAX_HEIGHT);
      oor_in     = ({1'b0, req_fields.x_coord} >= eff_width)
                || ({1'b0, req_fields.y_coord} >= eff_height);
      lin_addr   = fbaob_pkg::LIN_W'(req_fields.y_coord) * fbaob_pkg::LIN_W'(eff_width)
                 + fbaob_pkg::LIN_W'(req_fields.x_coord);
      addr_in    = ADDR_W'(lin_addr);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbaob_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = fbaob_pkg::ST_READ;
            end
         end
         fbaob_pkg::ST_READ: begin
            if (!oor_ff && op_ff == fbaob_pkg::OP_BLEND) begin
               state_in = fbaob_pkg::ST_BLEND;
            end else begin
               state_in = fbaob_pkg::ST_FINISH;
            end
         end
         fbaob_pkg::ST_BLEND: begin
            if (blend_stat.done) begin
               state_in = fbaob_pkg::ST_FINISH;
            end
         end
         fbaob_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = fbaob_pkg::ST_IDLE;
            end
         end
         default: state_in = fbaob_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      blend_start = 1'b0;
      pix_load    = 1'b0;
      pix_in      = mem_rdata;
      mem_we      = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         fbaob_pkg::ST_IDLE: req_tready = 1'b1;
         fbaob_pkg::ST_READ: begin
            blend_start = !oor_ff && op_ff == fbaob_pkg::OP_BLEND;
            pix_load    = 1'b1;
            if (oor_ff) begin
               pix_in = '0;
            end else if (op_ff == fbaob_pkg::OP_WRITE) begin
               pix_in = src_ff;
            end
         end
         fbaob_pkg::ST_BLEND: begin
            pix_load = blend_stat.done;
            pix_in   = blend_pix;
         end
         fbaob_pkg::ST_FINISH: begin
            rsp_load = slot_free;
            mem_we   = slot_free && !oor_ff
                    && (op_ff inside {fbaob_pkg::OP_BLEND, fbaob_pkg::OP_WRITE});
         end
         default: req_tready = 1'b0;
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fbaob_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= fbaob_pkg::CSR_DATA_W'(128);
         frame_height_ff <= fbaob_pkg::CSR_DATA_W'(128);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               fbaob_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               fbaob_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
               default: frame_width_ff <= frame_width_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_tuser;
         oor_ff  <= oor_in;
         addr_ff <= addr_in;
         src_ff  <= req_fields.color;
      end
      if (pix_load) begin
         pix_ff <= pix_in;
      end
      if (rsp_load) begin
         rsp_pix_ff <= pix_ff;
         rsp_oor_ff <= oor_ff;
      end
   end

   fbaob_ram #(
      .WIDTH (fbaob_pkg::PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (addr_ff),
      .wr_data (pix_ff),
      .rd_en   (req_accept),
      .rd_addr (addr_in),
      .rd_data (mem_rdata)
   );

   fbaob_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .start  (blend_start),
      .src    (src_ff),
      .dst    (mem_rdata),
      .result (blend_pix),
      .status (blend_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = rsp_oor_ff;

   `FBAOB_ASSERT(a_write_in_finish, clock, reset, mem_we |-> (state_ff == fbaob_pkg::ST_FINISH && !oor_ff), "Store written outside the finish step or out of range.")
   `FBAOB_ASSERT(a_done_in_blend, clock, reset, blend_stat.done |-> (state_ff == fbaob_pkg::ST_BLEND), "Blend unit finished while no blend was pending.")
   `FBAOB_ASSERT_NEXT(a_accept_reads, clock, reset, req_accept, (state_ff == fbaob_pkg::ST_READ), "Accepted transfer did not move to the read step.")
   `FBAOB_ASSERT(a_start_idle, clock, reset, blend_start |-> !blend_stat.busy, "Blend started while the unit was busy.")

endmodule

// ----- design/fbaob_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fbaob_ram #(
   parameter int WIDTH = fbaob_pkg::PIXEL_W,
   parameter int DEPTH = fbaob_pkg::STORE_DEPTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/fbaob_blend.sv -----
// Source-over blend unit: weight stage, numerator stage and a radix-4 divider.
`include "framebuffer_alpha_over_blend_macros.svh"

module fbaob_blend (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  fbaob_pkg::pixel_type        src,
   input  fbaob_pkg::pixel_type        dst,
   output fbaob_pkg::pixel_type        result,
   output fbaob_pkg::blend_status_type status
);

   fbaob_pkg::blend_state_type state_ff, state_in;
   logic [fbaob_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic load_weights, load_div, div_step;

   logic [fbaob_pkg::WT_W-1:0]   ws_ff, wd_ff;
   logic [fbaob_pkg::CHAN_W-1:0] src_ch_ff [fbaob_pkg::NUM_CHAN];
   logic [fbaob_pkg::CHAN_W-1:0] dst_ch_ff [fbaob_pkg::NUM_CHAN];
   logic [fbaob_pkg::DEN_W-1:0]  den_ff;
   logic                         den_zero_ff;
   logic [fbaob_pkg::CHAN_W-1:0] alpha_ff;
   logic [fbaob_pkg::DEN_W-1:0]  rem_ff [fbaob_pkg::NUM_CHAN];
   logic [fbaob_pkg::CHAN_W-1:0] qn_ff  [fbaob_pkg::NUM_CHAN];

   logic [fbaob_pkg::DEN_W-1:0]  den_sum;
   logic [fbaob_pkg::DEN_W-1:0]  alpha_tmp;
   logic [fbaob_pkg::NUM_W-1:0]  num [fbaob_pkg::NUM_CHAN];
   logic [fbaob_pkg::DEN_W-1:0]  rem_nx [fbaob_pkg::NUM_CHAN];
   logic [fbaob_pkg::CHAN_W-1:0] qn_nx  [fbaob_pkg::NUM_CHAN];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbaob_pkg::B_IDLE: begin
            if (start) begin
               state_in = fbaob_pkg::B_PROD;
            end
         end
         fbaob_pkg::B_PROD: state_in = fbaob_pkg::B_DIV;
         fbaob_pkg::B_DIV: begin
            if (cnt_ff == fbaob_pkg::DIV_CNT_W'(fbaob_pkg::DIV_STEPS - 1)) begin
               state_in = fbaob_pkg::B_DONE;
            end
         end
         fbaob_pkg::B_DONE: state_in = fbaob_pkg::B_IDLE;
         default: state_in = fbaob_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      load_weights = 1'b0;
      load_div     = 1'b0;
      div_step     = 1'b0;
      cnt_in       = cnt_ff;
      status.busy  = 1'b1;
      status.done  = 1'b0;
      case (state_ff)
         fbaob_pkg::B_IDLE: begin
            load_weights = start;
            status.busy  = 1'b0;
         end
         fbaob_pkg::B_PROD: begin
            load_div = 1'b1;
            cnt_in   = '0;
         end
         fbaob_pkg::B_DIV: begin
            div_step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
         end
         fbaob_pkg::B_DONE: status.done = 1'b1;
         default: status.busy = 1'b0;
      endcase
   end

   always_comb begin
      den_sum   = fbaob_pkg::DEN_W'(ws_ff) + fbaob_pkg::DEN_W'(wd_ff);
      // Exact division by 255 for values up to 255 * 255.
      alpha_tmp = den_sum + 1'b1 + (den_sum >> 8);
      for (int c = 0; c < fbaob_pkg::NUM_CHAN; c++) begin
         num[c] = fbaob_pkg::NUM_W'(src_ch_ff[c]) * fbaob_pkg::NUM_W'(ws_ff)
                + fbaob_pkg::NUM_W'(dst_ch_ff[c]) * fbaob_pkg::NUM_W'(wd_ff);
      end
   end

   always_comb begin
      logic [fbaob_pkg::DEN_W-1:0]  rem;
      logic [fbaob_pkg::CHAN_W-1:0] qn;
      logic [fbaob_pkg::DEN_W:0]    trial;
      for (int c = 0; c < fbaob_pkg::NUM_CHAN; c++) begin
         rem = rem_ff[c];
         qn  = qn_ff[c];
         for (int k = 0; k < fbaob_pkg::DIV_BITS; k++) begin
            trial = {rem, qn[fbaob_pkg::CHAN_W-1]};
            qn    = {qn[fbaob_pkg::CHAN_W-2:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem   = fbaob_pkg::DEN_W'(trial - {1'b0, den_ff});
               qn[0] = 1'b1;
            end else begin
               rem = trial[fbaob_pkg::DEN_W-1:0];
            end
         end
         rem_nx[c] = rem;
         qn_nx[c]  = qn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbaob_pkg::B_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_weights) begin
         ws_ff <= fbaob_pkg::WT_W'(src.alpha) * fbaob_pkg::WT_W'(8'd255);
         wd_ff <= fbaob_pkg::WT_W'(dst.alpha) * fbaob_pkg::WT_W'(8'd255 - src.alpha);
         src_ch_ff[0] <= src.red;
         src_ch_ff[1] <= src.green;
         src_ch_ff[2] <= src.blue;
         dst_ch_ff[0] <= dst.red;
         dst_ch_ff[1] <= dst.green;
         dst_ch_ff[2] <= dst.blue;
      end
      if (load_div) begin
         den_ff      <= den_sum;
         den_zero_ff <= (den_sum == '0);
         alpha_ff    <= alpha_tmp[15:8];
         for (int c = 0; c < fbaob_pkg::NUM_CHAN; c++) begin
            rem_ff[c] <= num[c][fbaob_pkg::NUM_W-1:fbaob_pkg::CHAN_W];
            qn_ff[c]  <= num[c][fbaob_pkg::CHAN_W-1:0];
         end
      end else if (div_step) begin
         for (int c = 0; c < fbaob_pkg::NUM_CHAN; c++) begin
            rem_ff[c] <= rem_nx[c];
            qn_ff[c]  <= qn_nx[c];
         end
      end
   end

   always_comb begin
      if (den_zero_ff) begin
         result = '0;
      end else begin
         result.alpha = alpha_ff;
         result.blue  = qn_ff[2];
         result.green = qn_ff[1];
         result.red   = qn_ff[0];
      end
   end

   `FBAOB_ASSERT_NEXT(a_div_ends, clock, reset, (state_ff == fbaob_pkg::B_DIV && cnt_ff == fbaob_pkg::DIV_CNT_W'(fbaob_pkg::DIV_STEPS - 1)), (state_ff == fbaob_pkg::B_DONE), "Divider did not finish after its last step.")
   `FBAOB_ASSERT(a_start_when_idle, clock, reset, start |-> (state_ff == fbaob_pkg::B_IDLE), "Blend unit started while busy.")
   `FBAOB_ASSERT_NEXT(a_done_single, clock, reset, status.done, !status.done, "Done flag held for more than one cycle.")

endmodule

// ----- test/framebuffer_alpha_over_blend_tb.sv -----
// Testbench for the RGBA framebuffer with source-over blending and its range checks.
`timescale 1ns / 100ps

module framebuffer_alpha_over_blend_tb;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int STORE_SIZE = fbaob_pkg::MAX_WIDTH_DEF * fbaob_pkg::MAX_HEIGHT_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      fbaob_pkg::pixel_type pix;
      logic                 oor;
   } pixel_result_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [fbaob_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic [1:0]                         req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [fbaob_pkg::PIXEL_W-1:0]      rsp_tdata;
   logic                               rsp_tuser;
   logic                               csr_we;
   logic                               csr_addr;
   logic [fbaob_pkg::CSR_DATA_W-1:0]   csr_wdata;

   fbaob_pkg::pixel_type    frame_copy [0:STORE_SIZE-1];
   bit                      is_written [0:STORE_SIZE-1];
   int unsigned             written_addrs[$];
   pixel_result_type        pending_pixels[$];
   int unsigned             frame_w;
   int unsigned             frame_h;
   int unsigned             fail_count;
   int unsigned             idle_cycles;
   bit                      steady;

   framebuffer_alpha_over_blend DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      return (frame_w > fbaob_pkg::MAX_WIDTH_DEF) ? fbaob_pkg::MAX_WIDTH_DEF : frame_w;
   endfunction

   function automatic int unsigned eff_height();
      return (frame_h > fbaob_pkg::MAX_HEIGHT_DEF) ? fbaob_pkg::MAX_HEIGHT_DEF : frame_h;
   endfunction

   function automatic fbaob_pkg::pixel_type over_blend(fbaob_pkg::pixel_type dst,
                                                       fbaob_pkg::pixel_type src);
      int unsigned          ws;
      int unsigned          wd;
      int unsigned          den;
      fbaob_pkg::pixel_type res;
      ws = int'(src.alpha) * 255;
      wd = int'(dst.alpha) * (255 - int'(src.alpha));
      den = ws + wd;
      res = '0;
      if (den == 0) begin
         return res;
      end
      res.red   = fbaob_pkg::CHAN_W'((int'(src.red) * ws + int'(dst.red) * wd) / den);
      res.green = fbaob_pkg::CHAN_W'((int'(src.green) * ws + int'(dst.green) * wd) / den);
      res.blue  = fbaob_pkg::CHAN_W'((int'(src.blue) * ws + int'(dst.blue) * wd) / den);
      res.alpha = fbaob_pkg::CHAN_W'(den / 255);
      return res;
   endfunction

   function automatic pixel_result_type frame_update(logic [1:0] op, int unsigned x,
                                                     int unsigned y,
                                                     fbaob_pkg::pixel_type src);
      int unsigned      addr;
      pixel_result_type res;
      res.pix = '0;
      res.oor = 1'b0;
      if (x >= eff_width() || y >= eff_height()) begin
         res.oor = 1'b1;
         return res;
      end
      addr = y * eff_width() + x;
      if (op == fbaob_pkg::OP_BLEND) begin
         frame_copy[addr] = over_blend(frame_copy[addr], src);
      end else if (op == fbaob_pkg::OP_WRITE) begin
         frame_copy[addr] = src;
         if (!is_written[addr]) begin
            is_written[addr] = 1'b1;
            written_addrs.push_back(addr);
         end
      end
      res.pix = frame_copy[addr];
      return res;
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic fbaob_pkg::pixel_type rand_color();
      fbaob_pkg::pixel_type c;
      int unsigned          r;
      c = $urandom;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         c.alpha = 8'h00;
      end else if (r < 30) begin
         c.alpha = 8'hff;
      end
      return c;
   endfunction

   function automatic fbaob_pkg::pixel_type make_color(int unsigned red, int unsigned green,
                                                       int unsigned blue, int unsigned alpha);
      fbaob_pkg::pixel_type c;
      c.red = fbaob_pkg::CHAN_W'(red);
      c.green = fbaob_pkg::CHAN_W'(green);
      c.blue = fbaob_pkg::CHAN_W'(blue);
      c.alpha = fbaob_pkg::CHAN_W'(alpha);
      return c;
   endfunction

   task automatic send_item(logic [1:0] op, int unsigned x, int unsigned y,
                            fbaob_pkg::pixel_type color);
      fbaob_pkg::req_data_type d;
      int unsigned             gap;
      d.pad = '0;
      d.color = color;
      d.y_coord = y[fbaob_pkg::COORD_W-1:0];
      d.x_coord = x[fbaob_pkg::COORD_W-1:0];
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= op;
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_pixels.push_back(frame_update(op, x, y, color));
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_frame_size(int unsigned w, int unsigned h);
      wait_for_idle();
      csr_we <= 1'b1;
      csr_addr <= fbaob_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= w[fbaob_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      frame_w = w;
      csr_addr <= fbaob_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= h[fbaob_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      frame_h = h;
      csr_we <= 1'b0;
   endtask

   task automatic test_default_frame();
      send_item(fbaob_pkg::OP_WRITE, 0, 0, make_color(0, 0, 0, 0));
      send_item(fbaob_pkg::OP_WRITE, 127, 127, make_color(255, 255, 255, 255));
      send_item(fbaob_pkg::OP_READ, 0, 0, rand_color());
      send_item(OP_SPARE, 127, 127, rand_color());
      send_item(fbaob_pkg::OP_BLEND, 0, 0, make_color(200, 100, 50, 0));
      send_item(fbaob_pkg::OP_BLEND, 127, 127, make_color(9, 8, 7, 0));
      send_item(fbaob_pkg::OP_BLEND, 127, 127, make_color(8'h12, 8'h34, 8'h56, 255));
      send_item(fbaob_pkg::OP_WRITE, 64, 3, make_color(10, 250, 128, 128));
      send_item(fbaob_pkg::OP_BLEND, 64, 3, make_color(255, 0, 77, 128));
   endtask

   task automatic test_range_limits();
      set_frame_size(10, 6);
      send_item(fbaob_pkg::OP_WRITE, 9, 5, make_color(1, 2, 3, 4));
      send_item(fbaob_pkg::OP_READ, 9, 5, rand_color());
      send_item(fbaob_pkg::OP_WRITE, 10, 0, rand_color());
      send_item(fbaob_pkg::OP_BLEND, 0, 6, rand_color());
      send_item(fbaob_pkg::OP_READ, 127, 127, rand_color());
      send_item(OP_SPARE, 10, 5, rand_color());
      set_frame_size(255, 255);
      send_item(fbaob_pkg::OP_WRITE, 127, 127, make_color(255, 1, 128, 254));
      send_item(fbaob_pkg::OP_READ, 127, 127, rand_color());
      set_frame_size(0, 128);
      send_item(fbaob_pkg::OP_WRITE, 0, 0, rand_color());
      set_frame_size(128, 0);
      send_item(fbaob_pkg::OP_READ, 0, 0, rand_color());
      set_frame_size(1, 1);
      send_item(fbaob_pkg::OP_BLEND, 0, 0, make_color(40, 50, 60, 1));
      send_item(fbaob_pkg::OP_READ, 1, 0, rand_color());
   endtask

   task automatic run_size_phase(int unsigned w, int unsigned h, int unsigned count,
                                 bit no_idle);
      int unsigned ew;
      int unsigned eh;
      int unsigned r;
      int unsigned x;
      int unsigned y;
      int unsigned idx;
      int unsigned a;
      logic [1:0]  op;
      set_frame_size(w, h);
      steady = no_idle;
      ew = eff_width();
      eh = eff_height();
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 10 || ew == 0 || eh == 0) begin
            op = 2'($urandom_range(0, 3));
            x = ($urandom_range(0, 1) && ew < 128) ? ew : $urandom_range(0, 127);
            y = ($urandom_range(0, 1) && eh < 128) ? eh : $urandom_range(0, 127);
         end else if (r < 35 || written_addrs.size() == 0) begin
            op = fbaob_pkg::OP_WRITE;
            x = $urandom_range(0, ew - 1);
            y = $urandom_range(0, eh - 1);
         end else begin
            r = $urandom_range(0, 9);
            op = (r < 7) ? fbaob_pkg::OP_BLEND : ((r < 9) ? fbaob_pkg::OP_READ : OP_SPARE);
            if ($urandom_range(0, 1) && written_addrs.size() > 16) begin
               idx = written_addrs.size() - 1 - $urandom_range(0, 15);
            end else begin
               idx = $urandom_range(0, written_addrs.size() - 1);
            end
            a = written_addrs[idx];
            x = a % ew;
            y = a / ew;
            if (y >= eh) begin
               x = $urandom_range(0, ew - 1);
               y = $urandom_range(0, eh - 1);
            end
         end
         // Reads and blends never touch a pixel that holds no written value.
         if (x < ew && y < eh && op != fbaob_pkg::OP_WRITE && !is_written[y * ew + x]) begin
            op = fbaob_pkg::OP_WRITE;
         end
         send_item(op, x, y, rand_color());
      end
      wait_for_idle();
      steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      run_size_phase(128, 128, 100, 1'b0);
      run_size_phase(1, 1, 90, 1'b0);
      run_size_phase(16, 8, 100, 1'b0);
      run_size_phase(255, 255, 90, 1'b0);
      run_size_phase(0, 40, 30, 1'b0);
      run_size_phase(40, 0, 30, 1'b0);
      run_size_phase(3, 128, 110, 1'b1);
      run_size_phase(128, 2, 110, 1'b0);
      run_size_phase(129, 1, 90, 1'b0);
      run_size_phase(200, 9, 100, 1'b0);
      run_size_phase(7, 5, 150, 1'b0);
      run_size_phase(64, 64, 150, 1'b0);
   endtask

   initial begin
      int unsigned hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (steady) begin
            rsp_tready <= 1'b1;
            hold = 0;
         end else if (hold == 0) begin
            if ($urandom_range(0, 1)) begin
               rsp_tready <= 1'b1;
               hold = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 12);
            end else begin
               rsp_tready <= 1'b0;
               hold = idle_len();
            end
         end else begin
            hold--;
         end
      end
   end

   always @(posedge clock) begin
      pixel_result_type     want;
      fbaob_pkg::pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_pixels.size() == 0) begin
            if (fail_count < REPORT_LIMIT) begin
               $display("unexpected result transfer: pixel %h range flag %b", got, rsp_tuser);
            end
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (got.red !== want.pix.red || got.green !== want.pix.green ||
                got.blue !== want.pix.blue || got.alpha !== want.pix.alpha ||
                rsp_tuser !== want.oor) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("result mismatch: expected rgba %h %h %h %h flag %b, got %h %h %h %h flag %b",
                           want.pix.red, want.pix.green, want.pix.blue, want.pix.alpha, want.oor,
                           got.red, got.green, got.blue, got.alpha, rsp_tuser);
               end
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= fbaob_pkg::OP_BLEND;
      csr_we <= 1'b0;
      csr_addr <= fbaob_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      frame_w = fbaob_pkg::MAX_WIDTH_DEF;
      frame_h = fbaob_pkg::MAX_HEIGHT_DEF;
      fail_count = 0;
      idle_cycles = 0;
      steady = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_frame();
      test_range_limits();
      test_random_traffic();
      wait_for_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
